[rtl/b64d_pkg.sv]
// Shared types and constants of the URL-safe Base64 decoder.
package b64d_pkg;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [1:0] ST_CAPACITY = 2'd2;
    localparam logic [1:0] ST_LONE     = 2'd3;

    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int MAX_RES    = 3;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        message_end;
        logic [1:0]  status;
        logic [15:0] byte_count;
    } res_t;

endpackage

[rtl/base64url_decoder_unit.sv]
// Streaming URL-safe Base64 (no padding) decoder with an output result queue.
//
// One character is accepted per clock cycle while s_ready is high. Each character
// causes zero to three result transactions, which are decoded in a single pass
// and written into an eight-entry result queue in the same cycle; the queue hands
// out one result per cycle while m_ready is high, so with an empty queue the
// first result of a character is available in the cycle after it is accepted.
// s_ready is high while at least three queue slots are free, which holds while
// m_ready is high because four characters yield at most three bytes. The decode
// state, the byte counter and the queue occupancy are the only loop.
module base64url_decoder_unit
    import b64d_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_is_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_data_byte,
    output logic        m_byte_valid,
    output logic        m_message_end,
    output logic [1:0]  m_status,
    output logic [15:0] m_byte_count
);

    localparam int W = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 2;
    localparam logic [W-1:0] CNT_MAX = W'((64'd1 << COUNT_WIDTH) - 64'd1);

    logic [15:0]            cap_reg;
    logic [1:0]             pos_reg, pos_next;
    logic [17:0]            acc_reg, acc_next;
    logic [COUNT_WIDTH-1:0] bw_reg, bw_next;
    logic                   discard_reg, discard_next;

    res_t                   mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;

    logic                   accept, pop;
    logic [5:0]             sextet;
    logic                   char_ok;
    logic [23:0]            word;
    logic [W-1:0]           cap_w, bw_w;
    logic [1:0]             n_res;
    res_t                   res [MAX_RES];

    assign accept  = s_valid && s_ready;
    assign pop     = m_valid && m_ready;
    assign s_ready = count_reg <= CNT_W'(FIFO_DEPTH - MAX_RES);
    assign m_valid = count_reg != '0;

    assign m_data_byte   = mem_reg[rd_ptr_reg].data_byte;
    assign m_byte_valid  = mem_reg[rd_ptr_reg].byte_valid;
    assign m_message_end = mem_reg[rd_ptr_reg].message_end;
    assign m_status      = mem_reg[rd_ptr_reg].status;
    assign m_byte_count  = mem_reg[rd_ptr_reg].byte_count;

    // Alphabet lookup.
    always_comb begin
        char_ok = 1'b1;
        sextet  = '0;
        case (s_char_code) inside
            [8'h41:8'h5A]: sextet = 6'(s_char_code - 8'h41);
            [8'h61:8'h7A]: sextet = 6'(s_char_code - 8'h61 + 8'd26);
            [8'h30:8'h39]: sextet = 6'(s_char_code - 8'h30 + 8'd52);
            8'h2D:         sextet = 6'd62;
            8'h5F:         sextet = 6'd63;
            default:       char_ok = 1'b0;
        endcase
    end

    assign word  = {acc_reg, sextet};
    assign cap_w = (W'(cap_reg) > CNT_MAX) ? CNT_MAX : W'(cap_reg);
    assign bw_w  = W'(bw_reg);

    always_comb begin
        pos_next     = pos_reg;
        acc_next     = acc_reg;
        bw_next      = bw_reg;
        discard_next = discard_reg;
        n_res        = 2'd0;
        for (int i = 0; i < MAX_RES; i++) begin
            res[i] = '{data_byte: 8'd0, byte_valid: 1'b0, message_end: 1'b0,
                       status: ST_OK, byte_count: bw_w[15:0]};
        end

        if (accept) begin
            if (discard_reg) begin
                if (s_is_last) begin
                    discard_next = 1'b0;
                end
            end else begin
                // An error result closes the message; these are overridden below
                // wherever the character does not end it.
                n_res              = 2'd1;
                res[0].message_end = 1'b1;
                pos_next           = '0;
                acc_next           = '0;
                bw_next            = '0;
                discard_next       = !s_is_last;
                if (!char_ok) begin
                    res[0].status = ST_BAD_CHAR;
                end else if (pos_reg == 2'd3) begin
                    if (cap_w < bw_w + W'(3)) begin
                        res[0].status = ST_CAPACITY;
                    end else begin
                        n_res        = 2'd3;
                        discard_next = 1'b0;
                        res[0] = '{data_byte: word[23:16], byte_valid: 1'b1,
                                   message_end: 1'b0, status: ST_OK,
                                   byte_count: 16'(bw_w + W'(1))};
                        res[1] = '{data_byte: word[15:8], byte_valid: 1'b1,
                                   message_end: 1'b0, status: ST_OK,
                                   byte_count: 16'(bw_w + W'(2))};
                        res[2] = '{data_byte: word[7:0], byte_valid: 1'b1,
                                   message_end: s_is_last, status: ST_OK,
                                   byte_count: 16'(bw_w + W'(3))};
                        bw_next = s_is_last ? '0 : COUNT_WIDTH'(bw_w + W'(3));
                    end
                end else if (!s_is_last) begin
                    n_res        = 2'd0;
                    discard_next = 1'b0;
                    acc_next     = word[17:0];
                    pos_next     = pos_reg + 2'd1;
                    bw_next      = bw_reg;
                end else if (pos_reg == 2'd0) begin
                    res[0].status = ST_LONE;
                end else if (pos_reg == 2'd1) begin
                    if (cap_w < bw_w + W'(1)) begin
                        res[0].status = ST_CAPACITY;
                    end else begin
                        res[0] = '{data_byte: word[11:4], byte_valid: 1'b1,
                                   message_end: 1'b1, status: ST_OK,
                                   byte_count: 16'(bw_w + W'(1))};
                    end
                end else begin
                    if (cap_w < bw_w + W'(2)) begin
                        res[0].status = ST_CAPACITY;
                    end else begin
                        n_res  = 2'd2;
                        res[0] = '{data_byte: word[17:10], byte_valid: 1'b1,
                                   message_end: 1'b0, status: ST_OK,
                                   byte_count: 16'(bw_w + W'(1))};
                        res[1] = '{data_byte: word[9:2], byte_valid: 1'b1,
                                   message_end: 1'b1, status: ST_OK,
                                   byte_count: 16'(bw_w + W'(2))};
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= 16'hFFFF;
            pos_reg     <= '0;
            acc_reg     <= '0;
            bw_reg      <= '0;
            discard_reg <= 1'b0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            pos_reg     <= pos_next;
            acc_reg     <= acc_next;
            bw_reg      <= bw_next;
            discard_reg <= discard_next;
            wr_ptr_reg  <= wr_ptr_reg + PTR_W'(n_res);
            rd_ptr_reg  <= rd_ptr_reg + PTR_W'(pop);
            count_reg   <= count_reg + CNT_W'(n_res) - CNT_W'(pop);
        end
    end

    // Result queue storage; several slots may be filled in one cycle.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (2'(i) < n_res) begin
                mem_reg[wr_ptr_reg + PTR_W'(i)] <= res[i];
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_discard_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && discard_reg) |-> (n_res == 2'd0))
        else $error("dropped character produced a result");

    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (!m_byte_valid && m_message_end))
        else $error("error result must end the message without a byte");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_is_last && !discard_reg) |=> (pos_reg == 2'd0 && bw_reg == '0))
        else $error("decode state not cleared at message end");

endmodule

[bench/b64url_decode_checker.sv]
// Watches the decoder's channels, predicts every result and compares it field by field.
module b64url_decode_checker
    import b64d_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_is_last,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_data_byte,
    input  logic        m_byte_valid,
    input  logic        m_message_end,
    input  logic [1:0]  m_status,
    input  logic [15:0] m_byte_count,
    output int          mismatch_count,
    output int          pending_results
);

    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0] capacity_reg;
    logic [1:0]  group_fill;
    logic [17:0] sextet_acc;
    logic [15:0] message_bytes;
    logic        dropping;
    res_t        decoded_q[$];
    res_t        want;

    // Bit 6 is set when the character belongs to the URL-safe alphabet.
    function automatic logic [6:0] sextet_of_char(logic [7:0] c);
        if (c >= "A" && c <= "Z") return {1'b1, 6'(c - "A")};
        if (c >= "a" && c <= "z") return {1'b1, 6'(c - "a" + 8'd26)};
        if (c >= "0" && c <= "9") return {1'b1, 6'(c - "0" + 8'd52)};
        if (c == "-") return {1'b1, 6'd62};
        if (c == "_") return {1'b1, 6'd63};
        return 7'd0;
    endfunction

    function automatic void end_message(logic last);
        group_fill    = 2'd0;
        sextet_acc    = '0;
        message_bytes = '0;
        dropping      = !last;
    endfunction

    function automatic void emit(logic [7:0] b, logic is_byte, logic fin, logic [1:0] st);
        res_t r;
        r.data_byte   = b;
        r.byte_valid  = is_byte;
        r.message_end = fin;
        r.status      = st;
        r.byte_count  = message_bytes;
        decoded_q.push_back(r);
    endfunction

    function automatic void emit_byte(logic [7:0] b, logic fin);
        message_bytes++;
        emit(b, 1'b1, fin, ST_OK);
        if (fin) end_message(1'b1);
    endfunction

    function automatic void emit_error(logic [1:0] st, logic last);
        emit(8'h00, 1'b0, 1'b1, st);
        end_message(last);
    endfunction

    function automatic void decode_char(logic [7:0] c, logic last);
        logic [6:0]  sx;
        logic [23:0] word;
        int          room;
        if (dropping) begin
            if (last) dropping = 1'b0;
            return;
        end
        sx = sextet_of_char(c);
        if (!sx[6]) begin
            emit_error(ST_BAD_CHAR, last);
            return;
        end
        word = {sextet_acc, sx[5:0]};
        room = (capacity_reg > message_bytes) ? int'(capacity_reg) - int'(message_bytes) : 0;
        if (group_fill == 2'd3) begin
            if (room < 3) begin
                emit_error(ST_CAPACITY, last);
                return;
            end
            emit_byte(word[23:16], 1'b0);
            emit_byte(word[15:8], 1'b0);
            emit_byte(word[7:0], last);
            group_fill = 2'd0;
            sextet_acc = '0;
            return;
        end
        if (!last) begin
            sextet_acc = word[17:0];
            group_fill = group_fill + 2'd1;
            return;
        end
        if (group_fill == 2'd0) begin
            emit_error(ST_LONE, 1'b1);
        end else if (group_fill == 2'd1) begin
            if (room < 1) emit_error(ST_CAPACITY, 1'b1);
            else emit_byte(word[11:4], 1'b1);
        end else begin
            if (room < 2) begin
                emit_error(ST_CAPACITY, 1'b1);
            end else begin
                emit_byte(word[17:10], 1'b0);
                emit_byte(word[9:2], 1'b1);
            end
        end
    endfunction

    function automatic void compare_field(string name, int unsigned exp_v, int unsigned got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg  = 16'hFFFF;
            group_fill    = 2'd0;
            sextet_acc    = '0;
            message_bytes = '0;
            dropping      = 1'b0;
            decoded_q.delete();
        end else begin
            if (cfg_wr_en) capacity_reg = cfg_wr_data;
            // The input side goes first so that the queue is in transaction order.
            if (s_valid && s_ready) decode_char(s_char_code, s_is_last);
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    $display({"%0t: unexpected result, expected none, ",
                              "got byte %0d valid %0d end %0d status %0d count %0d"},
                             $time, m_data_byte, m_byte_valid, m_message_end, m_status,
                             m_byte_count);
                    mismatch_count++;
                end else begin
                    want = decoded_q.pop_front();
                    compare_field("data_byte", want.data_byte, m_data_byte);
                    compare_field("byte_valid", want.byte_valid, m_byte_valid);
                    compare_field("message_end", want.message_end, m_message_end);
                    compare_field("status", want.status, m_status);
                    compare_field("byte_count", want.byte_count, m_byte_count);
                end
            end
        end
        pending_results <= decoded_q.size();
    end

endmodule

[bench/base64url_decoder_unit_test.sv]
// Top of the decoder test: clock, reset, character stimulus, result sink and verdict.
module base64url_decoder_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 150;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_char_code;
    logic        s_is_last;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_data_byte;
    logic        m_byte_valid;
    logic        m_message_end;
    logic [1:0]  m_status;
    logic [15:0] m_byte_count;
    int          mismatch_count;
    int          pending_results;

    int          chars_sent = 0;
    int          cycle_count = 0;
    bit          burst_mode = 1'b0;
    bit          sink_hold_req = 1'b0;

    always #2 aclk = ~aclk;

    base64url_decoder_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .s_is_last     (s_is_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_byte   (m_data_byte),
        .m_byte_valid  (m_byte_valid),
        .m_message_end (m_message_end),
        .m_status      (m_status),
        .m_byte_count  (m_byte_count)
    );

    b64url_decode_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_code     (s_char_code),
        .s_is_last       (s_is_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data_byte     (m_data_byte),
        .m_byte_valid    (m_byte_valid),
        .m_message_end   (m_message_end),
        .m_status        (m_status),
        .m_byte_count    (m_byte_count),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] b64_char(int v);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        return (v == 62) ? "-" : "_";
    endfunction

    function automatic logic [7:0] bad_char();
        string pool;
        int    pick;
        pool = "@[`{/:=+.!~ ";
        pick = $urandom_range(0, 2);
        if (pick == 0) return 8'h80 | 8'($urandom_range(0, 127));
        if (pick == 1) return 8'($urandom_range(0, 31));
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = burst_mode ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_code <= c;
        s_is_last   <= last;
        do @(posedge aclk); while (!s_ready);
        chars_sent++;
    endtask

    task automatic send_text(input string txt, input logic close_msg);
        for (int i = 0; i < txt.len(); i++) begin
            send_char(txt[i], close_msg && (i == txt.len() - 1));
        end
    endtask

    // Mostly well-formed messages with random content; some broken, some pure noise.
    task automatic send_random_message();
        int len;
        int kind;
        int bad_at;
        logic [7:0] c;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
        kind = $urandom_range(0, 9);
        if (kind >= 2 && len % 4 == 1 && $urandom_range(0, 3) != 0) len++;
        bad_at = (kind == 1) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
            if (kind == 0) c = 8'($urandom_range(0, 255));
            else if (i == bad_at) c = bad_char();
            else c = b64_char($urandom_range(0, 63));
            send_char(c, i == len - 1);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
        // A final character may cause no result while the block is still busy.
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [15:0] cap);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : result_sink
        bit sink_ready;
        int ready_left;
        int stall;
        sink_ready = 1'b1;
        ready_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                sink_ready    = 1'b0;
                ready_left    = HOLD_CYCLES;
            end else if (ready_left != 0) begin
                ready_left--;
            end else if (sink_ready) begin
                stall = idle_len();
                if (stall != 0) begin
                    sink_ready = 1'b0;
                    ready_left = stall - 1;
                end else begin
                    ready_left = $urandom_range(0, 40);
                end
            end else begin
                sink_ready = 1'b1;
                ready_left = $urandom_range(0, 40);
            end
            m_ready <= sink_ready;
        end
    end

    initial begin : stimulus
        logic [15:0] caps[10];
        int          phase_end;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_char_code <= '0;
        s_is_last   <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_capacity(16'hFFFF);
        send_text("AAAA", 1'b1);
        send_text("-_09", 1'b1);
        send_text("Zaz", 1'b1);
        // The unused low bits of a tail are ignored.
        send_text("QR", 1'b1);
        send_text("A", 1'b1);
        send_text("ABCDE", 1'b1);
        // A bad character in the middle drops the rest of the message.
        send_text("AB", 1'b0);
        send_char(8'h00, 1'b0);
        send_text("CD", 1'b1);
        send_text("Q", 1'b0);
        send_char(8'hFF, 1'b1);

        caps = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd8,
                 16'($urandom_range(0, 12)), 16'hFFFF, 16'd6};
        foreach (caps[i]) begin
            set_capacity(caps[i]);
            phase_end = chars_sent + 1;
            while (chars_sent < phase_end) send_random_message();
        end

        // Hold the result side while characters come at full rate, so the block backs up.
        set_capacity(16'hFFFF);
        sink_hold_req = 1'b1;
        burst_mode    = 1'b1;
        for (int i = 0; i < 16; i++) begin
            send_char(b64_char($urandom_range(0, 63)), i == 15);
        end
        burst_mode = 1'b0;
        send_random_message();

        wait_idle();
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[base64url_decoder_unit.f]
rtl/b64d_pkg.sv
rtl/base64url_decoder_unit.sv
bench/b64url_decode_checker.sv
bench/base64url_decoder_unit_test.sv
